// ----- rtl/core/sliding_window_median_defines.svh -----
// Assertion macros for the sliding window median RTL
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, switched off while reset is applied
`define SWM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// Clocked check that also covers the reset cycles
`define SWM_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(label, clk, rstn, prop, msg)
`define SWM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/swm_pkg.sv -----
// Shared constants and types of the sliding window median filter
package swm_pkg;

    // Deepest window the cell chain holds
    localparam int MAX_WINDOW = 64;

    // Sample width and window register width
    localparam int DATA_W = 32;
    localparam int WS_W   = 7;

    // Cell index, token rank and rotation counter width
    localparam int TAG_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Fill count width, able to hold MAX_WINDOW itself
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    // Common width for comparing the window register with the depth
    localparam int CMP_W  = (FILL_W > WS_W) ? FILL_W : WS_W;

    // Token that travels round the ring and collects its rank
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [TAG_W-1:0]         tag;
        logic [TAG_W-1:0]         cnt;
    } swm_token_t;

endpackage

// ----- rtl/core/sliding_window_median.sv -----
// Top level of the sliding window median filter
// Usage:
//   Samples enter on the s_ channel: s_tdata carries the signed sample and
//   s_tuser the start flag, which opens a new sequence with this sample.
//   Medians leave on the m_ channel as signed values in m_tdata.
//   cfg_wr_en / cfg_wr_data set the window size (0 acts as 1, sizes above
//   MAX_WINDOW act as MAX_WINDOW); write it only while the block is idle.
// Steps:
//   A sample that does not yet fill the window is taken in and the block stays idle.
//   A sample that yields a median goes through these steps: accept, load the
//   ranking tokens, rotate the tokens once round the cell ring, pick the
//   median; m_tvalid rises when the pick step hands the median to the output
//   register.
//   The next sample is accepted while a median waits in the output register.
// Reset:
//   Clears the fill count, the output valid and sets the window size to 1.
// Stall:
//   If m_tready stays low, the next median waits in the cell chain and no
//   further sample is accepted until the output register frees.
`include "sliding_window_median_defines.svh"

module sliding_window_median
    import swm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [WS_W-1:0]          cfg_wr_data,   // window_size
    // sample requests
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [DATA_W-1:0]        s_tdata,       // [31:0] sample
    input  logic                     s_tuser,       // start_req
    // median results
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [DATA_W-1:0]        m_tdata        // [31:0] median
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_ROT  = 4'b0100,
        S_SEL  = 4'b1000
    } swm_state_t;

    swm_state_t          state_reg, state_next;
    logic [WS_W-1:0]     ws_reg;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [TAG_W-1:0]    rot_cnt_reg, rot_cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                s_acc;
    logic [FILL_W-1:0]   fill_base;
    logic [FILL_W-1:0]   fill_acc;
    logic                res_due;
    logic [CMP_W-1:0]    ws_ext;
    logic [FILL_W-1:0]   win_eff;
    logic [TAG_W-1:0]    target;
    logic [DATA_W-1:0]   median_sel;

    logic signed [DATA_W-1:0] tap [MAX_WINDOW];
    swm_token_t               tok [MAX_WINDOW];
    logic [DATA_W-1:0]        sel_vals [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    hit_vec;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Clamp the window register to the chain depth
    always_comb begin
        ws_ext = CMP_W'(ws_reg);
        if (ws_ext == '0) begin
            win_eff = FILL_W'(1);
        end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
            win_eff = FILL_W'(MAX_WINDOW);
        end else begin
            win_eff = FILL_W'(ws_ext);
        end
    end

    // Zero-based rank of the lower median
    assign target = TAG_W'((win_eff - FILL_W'(1)) >> 1);

    // Fill count after this request, saturating at the depth
    assign fill_base = s_tuser ? '0 : fill_reg;
    assign fill_acc  = (fill_base < FILL_W'(MAX_WINDOW)) ? fill_base + FILL_W'(1) : fill_base;
    assign res_due   = (fill_acc >= win_eff);

    // Row of cells: tap shift line and a closed token ring
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        localparam int PREV = (g == 0) ? MAX_WINDOW - 1 : g - 1;
        logic signed [DATA_W-1:0] tap_in;

        if (g == 0) begin : g_head
            assign tap_in = $signed(s_tdata);
        end else begin : g_body
            assign tap_in = tap[PREV];
        end

        swm_cell u_cell (
            .aclk       (aclk),
            .shift_en   (s_acc),
            .load_en    (state_reg == S_LOAD),
            .rot_en     (state_reg == S_ROT),
            .cell_idx   (TAG_W'(g)),
            .win_eff    (win_eff),
            .target     (target),
            .sample_in  (tap_in),
            .sample_out (tap[g]),
            .tok_in     (tok[PREV]),
            .tok_out    (tok[g]),
            .hit        (hit_vec[g]),
            .sel_value  (sel_vals[g])
        );
    end

    // Gather the single hitting cell
    always_comb begin
        median_sel = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            median_sel = median_sel | sel_vals[i];
        end
    end

    // Sequence accept, token load, rotation and median hand-off
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rot_cnt_next  = rot_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    fill_next = fill_acc;
                    if (res_due) begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                state_next = S_ROT;
            end
            S_ROT: begin
                if (rot_cnt_reg == TAG_W'(MAX_WINDOW - 1)) begin
                    rot_cnt_next = '0;
                    state_next   = S_SEL;
                end else begin
                    rot_cnt_next = rot_cnt_reg + 1'b1;
                end
            end
            S_SEL: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = median_sel;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ws_reg       <= WS_W'(1);
            fill_reg     <= '0;
            rot_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rot_cnt_reg  <= rot_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                ws_reg <= cfg_wr_data;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // Exactly one cell holds the median rank when it is picked
    `SWM_ASSERT(a_one_hit, aclk, aresetn, (state_reg == S_SEL) |-> $onehot(hit_vec), "median rank not unique")
    // A request that fills the window starts a ranking pass
    `SWM_ASSERT(a_start_pass, aclk, aresetn, (s_acc && res_due) |=> (state_reg == S_LOAD), "ranking pass not started")
    // A median appears only out of the pick step
    `SWM_ASSERT(a_out_src, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == S_SEL), "median raised outside pick step")
    // Fill count stays within the chain depth
    `SWM_ASSERT(a_fill_max, aclk, aresetn, fill_reg <= FILL_W'(MAX_WINDOW), "fill count past depth")
    // Reset drops the output valid
    `SWM_ASSERT_RST(a_rst_out, aclk, !aresetn |=> !m_tvalid_reg, "output valid after reset")

endmodule

// ----- rtl/core/swm_cell.sv -----
// One cell of the median chain: a window tap plus a ranking token stage
module swm_cell
    import swm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     shift_en,
    input  logic                     load_en,
    input  logic                     rot_en,
    input  logic [TAG_W-1:0]         cell_idx,
    input  logic [FILL_W-1:0]        win_eff,
    input  logic [TAG_W-1:0]         target,
    input  logic signed [DATA_W-1:0] sample_in,
    output logic signed [DATA_W-1:0] sample_out,
    input  swm_token_t               tok_in,
    output swm_token_t               tok_out,
    output logic                     hit,
    output logic [DATA_W-1:0]        sel_value
);

    logic signed [DATA_W-1:0] val_reg;
    swm_token_t               tok_reg;
    swm_token_t               tok_next;
    logic                     in_window;
    logic                     below;

    // Cells past the window take no part in the ranking
    assign in_window = FILL_W'(cell_idx) < win_eff;

    // Order by value, ties broken by age so every rank is distinct
    assign below = (val_reg < tok_in.value) ||
                   ((val_reg == tok_in.value) && (cell_idx < tok_in.tag));

    // Count this cell into the passing token where it ranks lower
    always_comb begin
        tok_next = tok_in;
        if (in_window && below) begin
            tok_next.cnt = tok_in.cnt + 1'b1;
        end
    end

    // Shift the window tap and load or advance the token
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            val_reg <= sample_in;
        end
        if (load_en) begin
            tok_reg.value <= val_reg;
            tok_reg.tag   <= cell_idx;
            tok_reg.cnt   <= '0;
        end else if (rot_en) begin
            tok_reg <= tok_next;
        end
    end

    // Offer the value whose rank is the median one
    assign hit        = (FILL_W'(tok_reg.tag) < win_eff) && (tok_reg.cnt == target);
    assign sel_value  = hit ? tok_reg.value : '0;
    assign sample_out = val_reg;
    assign tok_out    = tok_reg;

endmodule

// ----- bench/tb_sliding_window_median.sv -----
// Self-checking testbench for the sliding window median filter
`timescale 1ns / 100ps

module tb_sliding_window_median;
    import swm_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1530;
    localparam int SETTLE_CYCLES  = MAX_WINDOW + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 40;

    localparam logic [DATA_W-1:0] SAMPLE_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;

    // Expected medians, worked out from the window contents seen so far
    class median_scoreboard;
        logic signed [DATA_W-1:0] history [MAX_WINDOW];
        logic signed [DATA_W-1:0] medians_due [$];
        logic [WS_W-1:0]          window_reg;
        int                       taken;
        int                       write_slot;
        int                       mismatches;

        function new();
            window_reg = WS_W'(1);
            taken      = 0;
            write_slot = 0;
            mismatches = 0;
        endfunction

        function void set_window(logic [WS_W-1:0] value);
            window_reg = value;
        endfunction

        // Zero acts as one, sizes beyond the deepest window are clipped
        function int span();
            int w;
            w = int'(window_reg);
            if (w == 0) begin
                w = 1;
            end
            if (w > MAX_WINDOW) begin
                w = MAX_WINDOW;
            end
            return w;
        endfunction

        // Take in an accepted sample request and queue the median it yields
        function void note_sample(logic signed [DATA_W-1:0] sample, logic start);
            logic signed [DATA_W-1:0] ranked [MAX_WINDOW];
            logic signed [DATA_W-1:0] v;
            int w;
            int i;
            int j;
            if (start) begin
                taken      = 0;
                write_slot = 0;
            end
            history[write_slot] = sample;
            write_slot = (write_slot + 1) % MAX_WINDOW;
            if (taken < MAX_WINDOW) begin
                taken++;
            end
            w = span();
            if (taken < w) begin
                return;
            end
            // Insertion sort of the newest w samples, ascending signed order
            for (i = 0; i < w; i++) begin
                v = history[(write_slot + MAX_WINDOW - 1 - i) % MAX_WINDOW];
                j = i;
                while (j > 0 && ranked[j-1] > v) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = v;
            end
            medians_due = {medians_due, ranked[(w + 1) / 2 - 1]};
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        // Compare a delivered median with the oldest one due
        task check_median(logic signed [DATA_W-1:0] got);
            logic signed [DATA_W-1:0] want;
            if (medians_due.size() == 0) begin
                report_mismatch($sformatf("median %0d with no sample waiting", got));
                return;
            end
            want = medians_due.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("median %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [WS_W-1:0]   cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata     = '0;    // [31:0] sample
    logic              s_tuser     = 1'b0;  // start_req
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [DATA_W-1:0] m_tdata;             // [31:0] median

    median_scoreboard board;
    int               tx_idle_pct  = 0;
    int               rx_stall_pct = 0;
    int               items_sent   = 0;

    sliding_window_median u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Write the window size; only called while the block is idle
    task automatic write_window(input logic [WS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_window(value);
    endtask

    // Offer one sample request after a random idle gap, hold until taken
    task automatic send_sample(input logic signed [DATA_W-1:0] sample, input logic start);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(sample, start);
        items_sent++;
    endtask

    // Drop the request, drain every median due, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.medians_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: stall at random and check every median taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                board.check_median(m_tdata);
            end
            m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Abort when neither channel moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int                       phase;
        int                       phase_end;
        int                       count;
        int                       k;
        logic [WS_W-1:0]          win;
        logic signed [DATA_W-1:0] sample;
        logic                     start;
        logic                     fresh;

        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window of one: sample extremes pass straight through
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b0);

        // Size zero behaves as one; a start request mid-stream
        settle();
        write_window('0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'h8000_0001, 1'b1);

        // Even window gives the lower median, with ties
        settle();
        write_window(7'd2);
        send_sample(32'sd5, 1'b1);
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd3, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(-32'sd3, 1'b0);

        // Odd window over the extremes, then a fresh sequence left unfilled
        settle();
        write_window(7'd3);
        send_sample(-32'sd1, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(32'sd10, 1'b1);
        send_sample(32'sd20, 1'b0);

        // Shrink the window mid-sequence: takes effect on the next sample
        settle();
        write_window(7'd2);
        send_sample(32'sd15, 1'b0);

        // Random sequences under each idling pattern
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 86;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 86;
                end
                default: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 10;
                end
            endcase
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end) begin
                settle();
                // Mostly short windows, with the limits and clipped sizes mixed in
                case ($urandom_range(15, 0))
                    0:       win = '0;
                    1:       win = 7'd127;
                    2:       win = WS_W'(MAX_WINDOW);
                    3:       win = WS_W'($urandom_range(126, MAX_WINDOW + 1));
                    4, 5:    win = WS_W'($urandom_range(MAX_WINDOW - 1, 9));
                    default: win = WS_W'($urandom_range(8, 1));
                endcase
                write_window(win);
                count = board.span() + $urandom_range(40, 0);
                if ($urandom_range(3, 0) == 0) begin
                    count += MAX_WINDOW;
                end
                fresh = ($urandom_range(3, 0) != 0);
                for (k = 0; k < count && items_sent < phase_end; k++) begin
                    start = (k == 0) ? fresh : ($urandom_range(49, 0) == 0);
                    case ($urandom_range(7, 0))
                        0: begin
                            case ($urandom_range(3, 0))
                                0:       sample = SAMPLE_MIN;
                                1:       sample = SAMPLE_MAX;
                                2:       sample = '0;
                                default: sample = '1;
                            endcase
                        end
                        1, 2:    sample = $signed($urandom_range(15, 0)) - 8;
                        default: sample = $urandom;
                    endcase
                    send_sample(sample, start);
                end
            end
        end

        settle();
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sliding_window_median.f -----
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median.sv
bench/tb_sliding_window_median.sv
